>>> hw/rtl/efd_pkg.sv
// Shared types, codes and constants of the event frame deframer.
package efd_pkg;

  // Width of the row and column coordinates.
  localparam int COORD_BITS = 12;
  // Width of the frame size registers.
  localparam int CFG_W = 13;
  // Width of the row and column sums, wide enough for a full column step.
  localparam int SUM_W = ((COORD_BITS > 12) ? COORD_BITS : 12) + 1;
  // Width in which sums are compared with the size limits.
  localparam int LIM_W = (SUM_W > CFG_W) ? SUM_W : CFG_W;

  // Configuration register indexes.
  localparam logic CFG_REG_ROWS = 1'b0;
  localparam logic CFG_REG_COLS = 1'b1;

  // Reset values of the frame size registers.
  localparam logic [CFG_W-1:0] ROWS_RESET = CFG_W'(720);
  localparam logic [CFG_W-1:0] COLS_RESET = CFG_W'(1280);

  // Result kinds.
  localparam logic [1:0] KIND_FRAME_START = 2'd0;
  localparam logic [1:0] KIND_PIXEL_GROUP = 2'd1;
  localparam logic [1:0] KIND_FRAME_END   = 2'd2;
  localparam logic [1:0] KIND_ERROR       = 2'd3;

  // Error codes.
  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_NO_HEADER = 2'd0;
  localparam logic [1:0] ERR_ROW_OVF   = 2'd1;
  localparam logic [1:0] ERR_COL_OVF   = 2'd2;
  localparam logic [1:0] ERR_TRUNCATED = 2'd3;

  // Stream byte values.
  localparam logic [7:0] SYNC_BYTE = 8'hF0;
  localparam logic [7:0] SYNC_LAST = 8'hFD;
  localparam logic [7:0] FILL_BYTE = 8'hFF;

  // Input word: one stream byte.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_buffer;
  } efd_in_t;

  // Output word: one decoded result.
  typedef struct packed {
    logic [1:0]            kind;
    logic [1:0]            error_code;
    logic [COORD_BITS-1:0] row;
    logic [COORD_BITS-1:0] col;
    logic [31:0]           polarities;
    logic [63:0]           timestamp;
    logic                  last_of_run;
  } efd_out_t;

endpackage

>>> hw/rtl/event_frame_deframer_core.sv
// Top level of the event frame deframer: header search, body decode and result queue.
//
//  Channel  Direction  Handshake                 Word
//  in_      input      in_valid / in_stall       efd_in_t (data_byte, end_of_buffer)
//  out_     output     out_valid / out_stall     efd_out_t (one decoded result)
//  cfg_     input      cfg_valid / cfg_ready     cfg_index, cfg_wdata (frame size)
//
// One byte is taken per cycle while in_stall is low; its results are written to a three-word
// queue at the same edge, and out_word shows the head of the queue.
// A byte that yields two results (a frame start or group followed by a truncation
// error) puts two words in the queue; in_stall rises while fewer than two queue slots are free.
// The divide of the gap by 1000 is a registered reciprocal multiply that settles
// long before the last header byte. Reset is synchronous and clears all control state.
module event_frame_deframer_core import efd_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  efd_in_t          in_word,
  output logic             out_valid,
  input  logic             out_stall,
  output efd_out_t         out_word,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata
);

  localparam logic [1:0] PH_SEARCH = 2'd0;
  localparam logic [1:0] PH_HEADER = 2'd1;
  localparam logic [1:0] PH_BODY   = 2'd2;
  localparam logic [1:0] PH_SKIP   = 2'd3;

  localparam int QDEPTH = 3;
  localparam logic [LIM_W-1:0] COORD_CAP = LIM_W'(1) << COORD_BITS;
  // ceil(2^36 / 125): the gap shifted right by three, times this, shifted by 36.
  localparam logic [29:0] DIV_MAGIC = 30'd549755814;

  // Configuration registers.
  logic [CFG_W-1:0] rows_r;
  logic [CFG_W-1:0] cols_r;

  // Decoder state.
  logic [1:0]            phase_r,  phase_nxt;
  logic [4:0]            bcnt_r,   bcnt_nxt;
  logic                  hok_r,    hok_nxt;
  logic [7:0]            la_r   [8];
  logic [7:0]            la_nxt [8];
  logic [7:0]            la_w   [8];
  logic [63:0]           trig_r;
  logic [31:0]           gap_r;
  logic [58:0]           div_prod_r;
  logic [COORD_BITS-1:0] row_r,    row_nxt;
  logic [COORD_BITS-1:0] col_r,    col_nxt;

  // Result queue.
  efd_out_t   q_r [QDEPTH];
  efd_out_t   q_nxt [QDEPTH];
  logic [1:0] qcnt_r, qcnt_nxt;

  logic     in_acc;
  logic     pop;
  logic [7:0] b;
  logic     eob;
  logic     main_vld;
  efd_out_t main_res;
  logic     eob_vld;
  efd_out_t eob_res;
  efd_out_t res0;
  efd_out_t res1;
  logic [1:0] nres;

  logic [LIM_W-1:0] row_lim;
  logic [LIM_W-1:0] col_lim;
  logic [LIM_W-1:0] row_sum;
  logic [LIM_W-1:0] col_sum;
  logic [2:0]       lcnt;
  logic [3:0]       lcnt1;
  logic             non_ff;
  logic [4:0]       kk;
  logic [22:0]      quot;

  assign b      = in_word.data_byte;
  assign eob    = in_word.end_of_buffer;
  assign in_acc = in_valid && !in_stall;
  assign pop    = out_valid && !out_stall;

  assign cfg_ready = 1'b1;
  assign in_stall  = (qcnt_r > 2'd1);
  assign out_valid = (qcnt_r != 2'd0);
  assign out_word  = q_r[0];

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= ROWS_RESET;
      cols_r <= COLS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_REG_ROWS) begin
        rows_r <= cfg_wdata;
      end else begin
        cols_r <= cfg_wdata;
      end
    end
  end

  // Effective limits never exceed the coordinate range.
  always_comb begin
    row_lim = (LIM_W'(rows_r) < COORD_CAP) ? LIM_W'(rows_r) : COORD_CAP;
    col_lim = (LIM_W'(cols_r) < COORD_CAP) ? LIM_W'(cols_r) : COORD_CAP;
  end

  // Gap divided by 1000, as a reciprocal multiply registered every cycle.
  always_ff @(posedge clk) begin
    div_prod_r <= gap_r[31:3] * DIV_MAGIC;
  end
  assign quot = div_prod_r[58:36];

  // Lookahead with the current byte written at the fill position.
  assign lcnt  = bcnt_r[2:0];
  assign lcnt1 = {1'b0, lcnt} + 4'd1;
  assign kk    = bcnt_r;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      la_w[i] = (3'(i) == lcnt) ? b : la_r[i];
    end
    non_ff = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if ((4'(i) < lcnt1) && (la_w[i] != FILL_BYTE)) begin
        non_ff = 1'b1;
      end
    end
    row_sum = LIM_W'(row_r) + LIM_W'(la_w[1]);
    col_sum = LIM_W'(col_r) + (LIM_W'(la_w[0]) << 4);
  end

  // Per-byte decode.
  always_comb begin
    logic [1:0] ph;
    logic       in_frame;
    logic       done;
    logic       restart;

    phase_nxt = phase_r;
    bcnt_nxt  = bcnt_r;
    hok_nxt   = hok_r;
    row_nxt   = row_r;
    col_nxt   = col_r;
    la_nxt    = la_r;
    main_vld  = 1'b0;
    main_res  = '0;
    eob_vld   = 1'b0;
    eob_res   = '0;
    in_frame  = 1'b0;
    done      = 1'b0;
    restart   = 1'b0;
    ph        = phase_r;

    // Trailing fill bytes after a tail are dropped; any other byte opens a search.
    if (phase_r == PH_SKIP) begin
      if (b != FILL_BYTE) begin
        ph       = PH_SEARCH;
        bcnt_nxt = 5'd0;
        hok_nxt  = 1'b1;
      end
    end

    unique case (ph)
      PH_SKIP: begin
        done = 1'b1;
        if (eob) begin
          restart = 1'b1;
        end
      end
      PH_SEARCH: begin
        if (bcnt_nxt[2:0] == 3'd7) begin
          if (hok_nxt && (b == SYNC_LAST)) begin
            phase_nxt = PH_HEADER;
            bcnt_nxt  = 5'd8;
            in_frame  = 1'b1;
          end else begin
            phase_nxt = PH_SEARCH;
            bcnt_nxt  = 5'd0;
            hok_nxt   = 1'b1;
          end
        end else begin
          phase_nxt = PH_SEARCH;
          if (b != SYNC_BYTE) begin
            hok_nxt = 1'b0;
          end
          bcnt_nxt = bcnt_nxt + 5'd1;
        end
      end
      PH_HEADER: begin
        in_frame = 1'b1;
        if (kk == 5'd31) begin
          main_vld           = 1'b1;
          main_res.kind      = KIND_FRAME_START;
          main_res.timestamp = trig_r + 64'(quot);
          phase_nxt          = PH_BODY;
          bcnt_nxt           = 5'd0;
          row_nxt            = '0;
          col_nxt            = '0;
        end else begin
          bcnt_nxt = kk + 5'd1;
        end
      end
      PH_BODY: begin
        in_frame = 1'b1;
        la_nxt   = la_w;
        bcnt_nxt = {1'b0, lcnt1};
        if ((lcnt1 >= 4'd5) && non_ff) begin
          // A complete group: row skip or sixteen pixels.
          if (la_w[0] == FILL_BYTE) begin
            if (row_sum >= row_lim) begin
              main_vld            = 1'b1;
              main_res.kind       = KIND_ERROR;
              main_res.error_code = ERR_ROW_OVF;
            end else begin
              row_nxt = row_sum[COORD_BITS-1:0];
              col_nxt = '0;
            end
          end else begin
            if (col_sum >= col_lim) begin
              main_vld            = 1'b1;
              main_res.kind       = KIND_ERROR;
              main_res.error_code = ERR_COL_OVF;
            end else begin
              col_nxt             = col_sum[COORD_BITS-1:0];
              main_vld            = 1'b1;
              main_res.kind       = KIND_PIXEL_GROUP;
              main_res.row        = row_r;
              main_res.col        = col_sum[COORD_BITS-1:0];
              main_res.polarities = {la_w[4], la_w[3], la_w[2], la_w[1]};
            end
          end
          la_nxt[0] = la_w[5];
          la_nxt[1] = la_w[6];
          la_nxt[2] = la_w[7];
          bcnt_nxt  = {1'b0, lcnt1 - 4'd5};
          if (main_vld && (main_res.kind == KIND_ERROR)) begin
            in_frame = 1'b0;
            done     = 1'b1;
            restart  = 1'b1;
          end
        end else if (lcnt1 >= 4'd8) begin
          // Eight fill bytes at a group boundary: the tail.
          main_vld      = 1'b1;
          main_res.kind = KIND_FRAME_END;
          in_frame      = 1'b0;
          done          = 1'b1;
          phase_nxt     = PH_SKIP;
          bcnt_nxt      = 5'd0;
        end
      end
      default: begin
        phase_nxt = PH_SEARCH;
      end
    endcase

    // End of buffer outside a finished frame is an error.
    if (eob) begin
      if (!done) begin
        eob_vld            = 1'b1;
        eob_res.kind       = KIND_ERROR;
        eob_res.error_code = in_frame ? ERR_TRUNCATED : ERR_NO_HEADER;
      end
      restart = 1'b1;
    end

    if (restart) begin
      phase_nxt = PH_SEARCH;
      bcnt_nxt  = 5'd0;
      hok_nxt   = 1'b1;
    end
  end

  // Order the results of this byte and mark the last one.
  always_comb begin
    res0 = main_vld ? main_res : eob_res;
    res1 = eob_res;
    res0.last_of_run = !(main_vld && eob_vld);
    res1.last_of_run = 1'b1;
    nres = 2'(main_vld) + 2'(eob_vld);
  end

  // Decoder registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SEARCH;
      bcnt_r  <= '0;
      hok_r   <= 1'b1;
      row_r   <= '0;
      col_r   <= '0;
    end else if (in_acc) begin
      phase_r <= phase_nxt;
      bcnt_r  <= bcnt_nxt;
      hok_r   <= hok_nxt;
      row_r   <= row_nxt;
      col_r   <= col_nxt;
    end
  end

  // Lookahead and header fields.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      la_r <= la_nxt;
      if ((phase_r == PH_HEADER) && (kk >= 5'd8) && (kk < 5'd16)) begin
        trig_r[8*kk[2:0] +: 8] <= b;
      end
      if ((phase_r == PH_HEADER) && (kk >= 5'd20) && (kk < 5'd24)) begin
        gap_r[8*kk[1:0] +: 8] <= b;
      end
    end
  end

  // Result queue: pop at the head, then append this byte's results.
  always_comb begin
    logic [1:0] cnt_after;
    logic [1:0] push;

    push = in_acc ? nres : 2'd0;
    for (int i = 0; i < QDEPTH; i++) begin
      q_nxt[i] = q_r[i];
    end
    if (pop) begin
      for (int i = 0; i < QDEPTH - 1; i++) begin
        q_nxt[i] = q_r[i+1];
      end
    end
    cnt_after = qcnt_r - 2'(pop);
    for (int i = 0; i < QDEPTH; i++) begin
      if ((push != 2'd0) && (2'(i) == cnt_after)) begin
        q_nxt[i] = res0;
      end
      if ((push == 2'd2) && (2'(i) == cnt_after + 2'd1)) begin
        q_nxt[i] = res1;
      end
    end
    qcnt_nxt = cnt_after + push;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qcnt_r <= '0;
    end else begin
      qcnt_r <= qcnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

endmodule

>>> hw/rtl/efd_checker.sv
// Port checker of the event frame deframer and its binding to the top level.
module efd_checker import efd_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     in_stall,
  input logic     out_valid,
  input logic     out_stall,
  input efd_out_t out_word
);

  // A stalled result word holds until taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("result word changed while stalled");

  // Reset empties the result queue and frees the input.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("queue not empty after reset");

  // Pixel groups carry no error code and no timestamp.
  a_pixel_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_word.kind == KIND_PIXEL_GROUP)
      |-> (out_word.error_code == ERR_NONE) && (out_word.timestamp == 64'd0))
    else $error("pixel group with stray fields");

  // Errors carry no position, polarities or timestamp.
  a_error_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_word.kind == KIND_ERROR)
      |-> (out_word.row == '0) && (out_word.col == '0)
          && (out_word.polarities == 32'd0) && (out_word.timestamp == 64'd0))
    else $error("error result with stray fields");

endmodule

bind event_frame_deframer_core efd_checker u_efd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word  (out_word)
);
